FILE: rtl/core/tvt_pkg.sv
`timescale 1ns / 1ps
// tvt_pkg: shared types and constants of the touch velocity tracker.
// No dependencies; imported by every module of the block.
package tvt_pkg;

  localparam int GAP_W   = 16;
  localparam int WIN_W   = 20;
  localparam int SPEED_W = 31;
  localparam int NUM_W   = 52;
  localparam int QUO_W   = 32;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  // 256000 = 125 << 11; one more shift doubles the numerator for rounding
  localparam logic [6:0] SPEED_SCALE = 7'd125;
  localparam int SCALE_SHIFT = 12;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE  = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [1:0] REG_MIN_GAP   = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic decode;
    logic walk_init;
    logic walk_step;
    logic avg;
    logic mul;
    logic setup;
    logic div_step;
    logic post;
    logic out_load;
  } tvt_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       too_soon;
    logic       queue_empty;
    logic       walk_last;
    logic       cnt_gt1;
    logic       div_done;
  } tvt_status_t;

endpackage

FILE: rtl/core/tvt_ctrl.sv
`timescale 1ns / 1ps
// tvt_ctrl: sequencing state machine of the touch velocity tracker.
// Depends on tvt_pkg; drives the datapath through tvt_cmd_t.
module tvt_ctrl import tvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        out_free,
  input  tvt_status_t status,
  output tvt_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_WALK   = 9'b000001000,
    S_AVG    = 9'b000010000,
    S_SETUP  = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_POST   = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (status.action)
          ACT_START: begin
            cmd.start = 1'b1;
            state_nxt = S_IDLE;
          end
          ACT_SAMPLE: begin
            state_nxt = status.too_soon ? S_IDLE : S_MUL;
          end
          ACT_RELEASE: begin
            cmd.walk_init = 1'b1;
            state_nxt = status.queue_empty ? S_AVG : S_WALK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_SETUP;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) state_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.avg = 1'b1;
        state_nxt = status.cnt_gt1 ? S_SETUP : S_FIN;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = S_POST;
      end
      S_POST: begin
        cmd.post = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/core/tvt_dp.sv
`timescale 1ns / 1ps
// tvt_dp: datapath of the touch velocity tracker: reference sample, velocity
// queue, walk accumulator and a shared radix-2 divider. Depends on tvt_pkg.
module tvt_dp import tvt_pkg::*; #(
  parameter int QUEUE_DEPTH = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tvt_cmd_t            cmd,
  output tvt_status_t         status,
  input  logic [1:0]          in_action,
  input  logic signed [31:0]  in_position,
  input  logic [31:0]         in_timestamp,
  input  logic [GAP_W-1:0]    cfg_min_gap,
  input  logic [WIN_W-1:0]    cfg_window,
  input  logic [SPEED_W-1:0]  cfg_max_speed,
  output logic signed [31:0]  result,
  output logic                kind
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = 32 + $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_E  = (IDX_W + 1)'(QUEUE_DEPTH);

  logic [1:0]         action_r;
  logic [31:0]        pos_r;
  logic [31:0]        ts_r;
  logic               kind_r;
  logic [31:0]        last_time_r;
  logic [31:0]        last_pos_r;
  logic [31:0]        dt_r;
  logic               neg_r;
  logic [32:0]        mag_r;
  logic [NUM_W-1:0]   num_r;
  logic [31:0]        den_r;
  logic               ovf_r;
  logic [31:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [31:0]        stamp_r [QUEUE_DEPTH];
  logic signed [31:0] speed_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   head_r;
  logic [IDX_W-1:0]   ptr_r;
  logic [CNT_W-1:0]   walk_i_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]   acc_cnt_r;
  logic signed [31:0] result_r, result_nxt;

  // sample decode
  logic [31:0] dt_c;
  logic [32:0] d_c, mag_c;
  logic        too_soon_c;
  assign dt_c = ts_r - last_time_r;
  assign too_soon_c = !(!dt_c[31] && (dt_c > {16'b0, cfg_min_gap}));
  assign d_c = {last_pos_r[31], last_pos_r} - {pos_r[31], pos_r};
  assign mag_c = d_c[32] ? (33'd0 - d_c) : d_c;

  // scaled numerator: 2 * |d| * 256000 + dt
  logic [39:0]      prod_c;
  logic [NUM_W-1:0] num_mul_c;
  assign prod_c = 40'(mag_r) * 40'(SPEED_SCALE);
  assign num_mul_c = {prod_c, SCALE_SHIFT'(0)} + NUM_W'(dt_r);

  // queue walk
  logic [31:0]      age_c;
  logic             hit_c;
  logic [IDX_W-1:0] ptr_inc;
  assign age_c = ts_r - stamp_r[ptr_r];
  assign hit_c = age_c[31] || (age_c < {12'b0, cfg_window});
  assign ptr_inc = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;

  // average numerator: 2 * |sum| + count
  logic [SUM_W-1:0] abs_sum_c;
  logic [NUM_W-1:0] num_avg_c;
  assign abs_sum_c = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign num_avg_c = NUM_W'({abs_sum_c, 1'b0}) + NUM_W'(acc_cnt_r);

  // divider step
  logic [32:0] shifted_c, diff_c;
  logic        ge_c;
  logic        ovf_c;
  assign shifted_c = {rem_r, quo_r[QUO_W-1]};
  assign diff_c = shifted_c - {1'b0, den_r};
  assign ge_c = shifted_c >= {1'b0, den_r};
  assign ovf_c = {12'b0, num_r} >= {den_r, 32'b0};
  assign rem_nxt = ge_c ? diff_c[31:0] : shifted_c[31:0];
  assign quo_nxt = {quo_r[QUO_W-2:0], ge_c};

  // clamp and saturate
  logic [32:0] mag_eff_c, mag_clip_c;
  always_comb begin
    mag_eff_c = ovf_r ? 33'h1_0000_0000 : {1'b0, quo_r};
    mag_clip_c = mag_eff_c;
    if (!kind_r && (cfg_max_speed != '0) && (mag_eff_c > {2'b0, cfg_max_speed}))
      mag_clip_c = {2'b0, cfg_max_speed};
    if (neg_r) begin
      if (mag_clip_c >= 33'h0_8000_0000) result_nxt = 32'sh8000_0000;
      else                               result_nxt = 32'(33'd0 - mag_clip_c);
    end else begin
      if (mag_clip_c > 33'h0_7FFF_FFFF) result_nxt = 32'sh7FFF_FFFF;
      else                              result_nxt = mag_clip_c[31:0];
    end
  end

  // push slot
  logic [IDX_W:0]   slot_sum_c;
  logic [IDX_W-1:0] slot_c, head_inc;
  logic             full_c;
  assign full_c = (count_r == DEPTH_C);
  assign slot_sum_c = (IDX_W + 1)'(head_r) + (IDX_W + 1)'(count_r);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  always_comb begin
    if (full_c)                   slot_c = head_r;
    else if (slot_sum_c >= DEPTH_E) slot_c = IDX_W'(slot_sum_c - DEPTH_E);
    else                          slot_c = slot_sum_c[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      pos_r    <= in_position;
      ts_r     <= in_timestamp;
      kind_r   <= (in_action == ACT_RELEASE);
    end
    if (cmd.decode) begin
      dt_r  <= dt_c;
      neg_r <= d_c[32];
      mag_r <= mag_c;
    end
    if (cmd.mul) begin
      num_r <= num_mul_c;
      den_r <= {dt_r[30:0], 1'b0};
    end
    if (cmd.walk_init) begin
      ptr_r     <= head_r;
      walk_i_r  <= '0;
      sum_r     <= '0;
      acc_cnt_r <= '0;
    end
    if (cmd.walk_step) begin
      ptr_r    <= ptr_inc;
      walk_i_r <= walk_i_r + 1'b1;
      if (hit_c) begin
        sum_r     <= sum_r + SUM_W'(speed_r[ptr_r]);
        acc_cnt_r <= acc_cnt_r + 1'b1;
      end
    end
    if (cmd.avg) begin
      num_r    <= num_avg_c;
      den_r    <= 32'({acc_cnt_r, 1'b0});
      neg_r    <= sum_r[SUM_W-1];
      result_r <= sum_r[31:0];
    end
    if (cmd.setup) begin
      ovf_r     <= ovf_c;
      rem_r     <= 32'(num_r[NUM_W-1:32]);
      quo_r     <= num_r[31:0];
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      quo_r     <= quo_nxt;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.post) result_r <= result_nxt;
    if (cmd.post && !kind_r) begin
      stamp_r[slot_c] <= ts_r;
      speed_r[slot_c] <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      last_pos_r  <= '0;
      count_r     <= '0;
      head_r      <= '0;
    end else begin
      if (cmd.start) begin
        last_time_r <= ts_r;
        last_pos_r  <= pos_r;
        count_r     <= '0;
        head_r      <= '0;
      end
      if (cmd.avg || (cmd.post && kind_r)) begin
        count_r <= '0;
        head_r  <= '0;
      end
      if (cmd.post && !kind_r) begin
        last_time_r <= ts_r;
        last_pos_r  <= pos_r;
        if (full_c) head_r  <= head_inc;
        else        count_r <= count_r + 1'b1;
      end
    end
  end

  assign status.action      = action_r;
  assign status.too_soon    = too_soon_c;
  assign status.queue_empty = (count_r == '0);
  assign status.walk_last   = (CNT_W'(walk_i_r + 1'b1) == count_r);
  assign status.cnt_gt1     = (acc_cnt_r > CNT_W'(1));
  assign status.div_done    = (div_cnt_r == DIV_LAST);

  assign result = result_r;
  assign kind   = kind_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("queue count above depth");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_IDX) else $error("queue head out of range");
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (walk_i_r < count_r)) else $error("walk past queue end");
`endif

endmodule

FILE: rtl/core/touch_velocity_tracker.sv
`timescale 1ns / 1ps
// Start item, ignored sample, or unused action: decoded, then idle again; no result.
// Sample: decode, multiply, setup, 32-step radix-2 divider, clamp, then out_valid once the
// output register is free. Release with N queued entries: queue walk at one entry a cycle,
// then the average, and the divider only when more than one entry is recent.
// One item in flight; a held result does not block the next accept.
// Reset (rst_n low, synchronous) restores register defaults, empties the queue.
module touch_velocity_tracker import tvt_pkg::*; #(
  parameter int QUEUE_DEPTH = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_position,
  input  logic [31:0]        in_timestamp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_velocity,
  output logic               out_kind,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [GAP_W-1:0]   min_gap_r;
  logic [WIN_W-1:0]   window_r;
  logic [SPEED_W-1:0] max_speed_r;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_velocity_r;
  logic               out_kind_r;

  tvt_cmd_t           cmd;
  tvt_status_t        status;
  logic signed [31:0] dp_result;
  logic               dp_kind;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r   <= GAP_W'(5000);
      window_r    <= WIN_W'(100000);
      max_speed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_GAP:   min_gap_r   <= cfg_data[GAP_W-1:0];
        REG_WINDOW:    window_r    <= cfg_data[WIN_W-1:0];
        REG_MAX_SPEED: max_speed_r <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_velocity_r <= dp_result;
      out_kind_r     <= dp_kind;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_velocity = out_velocity_r;
  assign out_kind     = out_kind_r;

  tvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  tvt_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_timestamp  (in_timestamp),
    .cfg_min_gap   (min_gap_r),
    .cfg_window    (window_r),
    .cfg_max_speed (max_speed_r),
    .result        (dp_result),
    .kind          (dp_kind)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accept while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free) else $error("result register overwritten");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid) else $error("loaded result not shown");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for touch_velocity_tracker with an in-file velocity predictor.
// Depends on tvt_pkg and touch_velocity_tracker; directed gestures first, then random phases.
module tb import tvt_pkg::*; ();

  localparam int DEPTH = 5;
  localparam int QUIET_LIMIT = 2000;
  localparam bit KIND_SAMPLE = 1'b0;
  localparam bit KIND_RELEASE = 1'b1;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct {
    int velocity;
    bit kind;
  } velocity_t;

  class velocity_checker;
    int unsigned min_gap = 5000;
    int unsigned window = 100000;
    int unsigned speed_cap = 0;
    int unsigned ref_time = 0;
    int ref_pos = 0;
    int unsigned stamps[DEPTH];
    int speeds[DEPTH];
    int count = 0;
    int head = 0;
    int errors = 0;
    velocity_t pending_velocities[$];

    function int pending();
      return pending_velocities.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_MIN_GAP:   min_gap = 32'(data[15:0]);
        REG_WINDOW:    window = 32'(data[19:0]);
        REG_MAX_SPEED: speed_cap = 32'(data[30:0]);
        default: ;
      endcase
    endfunction

    function longint unsigned round_half_away(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
    endfunction

    function int saturate(bit neg, longint unsigned mag);
      if (neg)
        return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : int'(-longint'(mag));
      return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(mag);
    endfunction

    function void expect_velocity(int v, bit k);
      velocity_t e;
      e.velocity = v;
      e.kind = k;
      pending_velocities.push_back(e);
    endfunction

    // returns 1 when the item does something (not ignored)
    function bit note_event(logic [1:0] act, logic [31:0] pos, logic [31:0] ts);
      int dt;
      int age;
      int v;
      int slot;
      int hits;
      int i;
      longint d;
      longint total;
      longint unsigned mag;
      bit neg;
      case (act)
        ACT_START: begin
          count = 0;
          head = 0;
          ref_time = ts;
          ref_pos = pos;
          return 1'b1;
        end
        ACT_SAMPLE: begin
          dt = int'(ts - ref_time);
          if (longint'(dt) <= longint'(min_gap))
            return 1'b0;
          d = longint'(ref_pos) - longint'(int'(pos));
          neg = d < 0;
          mag = neg ? -d : d;
          mag = round_half_away(mag * 256000, longint'(dt));
          if (speed_cap != 0 && mag > speed_cap)
            mag = speed_cap;
          v = saturate(neg, mag);
          ref_time = ts;
          ref_pos = pos;
          if (count < DEPTH) begin
            slot = (head + count) % DEPTH;
            count++;
          end else begin
            slot = head;
            head = (head + 1) % DEPTH;
          end
          stamps[slot] = ts;
          speeds[slot] = v;
          expect_velocity(v, KIND_SAMPLE);
          return 1'b1;
        end
        ACT_RELEASE: begin
          total = 0;
          hits = 0;
          for (i = 0; i < count; i++) begin
            slot = (head + i) % DEPTH;
            age = int'(ts - stamps[slot]);
            if (longint'(age) < longint'(window)) begin
              total += longint'(speeds[slot]);
              hits++;
            end
          end
          count = 0;
          head = 0;
          if (hits > 1) begin
            neg = total < 0;
            mag = neg ? -total : total;
            v = saturate(neg, round_half_away(mag, longint'(hits)));
          end else begin
            v = int'(total);
          end
          expect_velocity(v, KIND_RELEASE);
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void check_velocity(logic signed [31:0] vel, logic k);
      velocity_t e;
      if (pending_velocities.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual velocity %0d kind %0d",
                 $time, vel, k);
        errors++;
        return;
      end
      e = pending_velocities.pop_front();
      if (vel !== e.velocity) begin
        $display("%0t: velocity mismatch, expected %0d actual %0d", $time, e.velocity, vel);
        errors++;
      end
      if (k !== e.kind) begin
        $display("%0t: kind mismatch, expected %0d actual %0d", $time, e.kind, k);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = ACT_START;
  logic signed [31:0] in_position = '0;
  logic [31:0] in_timestamp = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_velocity;
  logic out_kind;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_MIN_GAP;
  logic [31:0] cfg_data = '0;

  velocity_checker velocity_chk;
  bit calm = 1'b0;
  int live_items = 0;
  int ready_hold = 0;
  int quiet_cycles = 0;

  touch_velocity_tracker dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_position(in_position),
    .in_timestamp(in_timestamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_velocity(out_velocity),
    .out_kind(out_kind),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_hold = idle_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        velocity_chk.check_velocity(out_velocity, out_kind);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // valid stays high after acceptance; callers either send again or drain
  task automatic send_event(input logic [1:0] act, input logic [31:0] pos,
                            input logic [31:0] ts);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_position  <= pos;
    in_timestamp <= ts;
    do @(posedge clk); while (!in_ready);
    if (velocity_chk.note_event(act, pos, ts))
      live_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (velocity_chk.pending() != 0);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    velocity_chk.set_reg(idx, data);
  endtask

  task automatic write_regs(input logic [31:0] gap_word, input logic [31:0] win_word,
                            input logic [31:0] speed_word);
    put_reg(REG_MIN_GAP, gap_word);
    put_reg(REG_WINDOW, win_word);
    put_reg(REG_MAX_SPEED, speed_word);
    put_reg(REG_NONE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] sample_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return $urandom_range(0, velocity_chk.min_gap);
    if (r < 14)
      return $urandom;
    if (r < 18)
      return velocity_chk.min_gap + 1;
    return velocity_chk.min_gap + 1 + $urandom_range(0, velocity_chk.window / 3 + 2000);
  endfunction

  function automatic logic [31:0] pos_step();
    logic [31:0] span;
    if ($urandom_range(0, 9) == 0)
      return $urandom;
    span = 32'd1 << $urandom_range(0, 24);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] release_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(0, velocity_chk.window + 2000);
    if (r < 85)
      return -$urandom_range(1, 3000);
    return $urandom;
  endfunction

  task automatic run_gesture();
    logic [31:0] t;
    logic [31:0] p;
    int n;
    t = $urandom;
    p = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000000) - 1000000;
    if ($urandom_range(0, 9) != 0)
      send_event(ACT_START, p, t);
    else
      t = velocity_chk.ref_time;
    n = $urandom_range(1, 8);
    repeat (n) begin
      t += sample_step();
      p += pos_step();
      send_event(ACT_SAMPLE, p, t);
    end
    if ($urandom_range(0, 9) != 0) begin
      t += release_step();
      send_event(ACT_RELEASE, $urandom, t);
    end
  endtask

  initial begin
    logic [31:0] t;
    int phase;
    int goal;
    velocity_chk = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // against the reset reference, then single-entry and empty releases
    send_event(ACT_SAMPLE, 32'd25600, 32'd10000);
    send_event(ACT_RELEASE, 32'hFFFF_FFFF, 32'd10500);
    send_event(ACT_RELEASE, 32'h0, 32'd10600);
    send_event(ACT_UNUSED, 32'h8000_0000, 32'hFFFF_FFFF);
    t = 32'hFFFF_F000;
    send_event(ACT_START, 32'h7FFF_FFFF, t);
    t += 6000;
    send_event(ACT_SAMPLE, 32'h8000_0000, t);
    send_event(ACT_SAMPLE, 32'h0, t + 100);
    send_event(ACT_SAMPLE, 32'h0, t + 5000);
    send_event(ACT_SAMPLE, 32'h0, t - 7000);
    t += 5001;
    send_event(ACT_SAMPLE, 32'h7FFF_FFFF, t);
    t += 512000;
    send_event(ACT_SAMPLE, 32'h7FFF_FFFF, t);
    t += 512000;
    send_event(ACT_SAMPLE, 32'h7FFF_FFFE, t);
    t += 512000;
    send_event(ACT_SAMPLE, 32'h7FFF_FFFF, t);
    repeat (3) begin
      t += 6000;
      send_event(ACT_SAMPLE, $urandom, t);
    end
    send_event(ACT_RELEASE, 32'h0, t + 1000);
    send_event(ACT_RELEASE, 32'h0, t + 2000);

    live_items = 0;
    for (phase = 1; phase <= 11; phase++) begin
      drain();
      repeat (10) @(posedge clk);
      case (phase)
        1: write_regs(32'h0, 32'h0, 32'h0);
        2: write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: write_regs({16'($urandom), 16'd5000}, {12'($urandom), 20'd100000},
                      {1'($urandom), 31'd1});
        4: write_regs(32'h0, 32'h000F_FFFF, $urandom_range(1, 1 << 22));
        default: write_regs($urandom, $urandom,
                            $urandom_range(0, 1) ? ($urandom & 32'h8000_0000) : $urandom);
      endcase
      calm = (phase % 4 == 2);
      goal = live_items + 90;
      while (live_items < goal) begin
        if ($urandom_range(0, 6) == 0)
          send_event(2'($urandom_range(0, 3)), $urandom, $urandom);
        else
          run_gesture();
        if ($urandom_range(0, 19) == 0)
          drain();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (velocity_chk.errors == 0 && velocity_chk.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
